@@ src/crlf_line_ending_dot_stuffing_assert.svh @@
// Assertion macros used by the checker of the line-ending converter.
// No dependencies; include by bare file name inside a module body.
`ifndef CRLF_LINE_ENDING_DOT_STUFFING_ASSERT_SVH
`define CRLF_LINE_ENDING_DOT_STUFFING_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CRLF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("crlf assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CRLF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("crlf assertion failed");

// Same-cycle implication that is checked through reset as well.
`define CRLF_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error("crlf assertion failed");

`endif

@@ src/crlf_pkg.sv @@
// Constants of the CRLF / dot-stuffing converter: character codes,
// register indexes and field widths. No dependencies.
package crlf_pkg;

    localparam int BYTE_W = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;

    localparam logic [CFG_ADDR_W-1:0] REG_ENCODE_MODE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOT_MODE    = 1'b1;

endpackage

@@ src/crlf_line_ending_dot_stuffing.sv @@
// Channel   | dir | tdata (low bit up) | tuser | tlast
// s_ (in)   | in  | in_byte[7:0]       | -     | -
// m_ (out)  | out | out_byte[7:0]      | -     | last_of_run
// cfg       | in  | index 0 encode_mode, index 1 dot_mode, one bit of data
//
// One input byte is taken per cycle while s_tready is high; its zero to two
// result bytes are computed in the same cycle and land in a two-entry output queue.
// Output drains one byte per cycle while m_tready is high, so a byte that
// yields two results keeps s_tready low until its first result has left.
// s_tready is high when the queue is empty or its single entry leaves in this cycle.
// Reset (aresetn low, synchronous) empties the queue and restores modes
// and line state. A pending decode CR is never flushed.
// Depends on crlf_pkg.
module crlf_line_ending_dot_stuffing (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [crlf_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crlf_pkg::BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [crlf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [crlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import crlf_pkg::*;

    logic encode_reg, dot_reg;
    logic seen_cr_reg, seen_cr_next;
    logic line_start_reg, line_start_next;
    logic seen_dot_reg, seen_dot_next;

    logic [BYTE_W-1:0] byte_reg [2];
    logic [BYTE_W-1:0] byte_next [2];
    logic              last_reg [2];
    logic              last_next [2];
    logic [1:0]        cnt_reg, cnt_next;

    logic [1:0]        n_res;
    logic [BYTE_W-1:0] res [2];
    logic [BYTE_W-1:0] c;
    logic              s_xfer, m_xfer;

    assign c        = s_tdata;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = byte_reg[0];
    assign m_tlast  = last_reg[0];
    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign s_xfer   = s_tvalid && s_tready;

    // Results for the byte on s_tdata, and the line state it leaves.
    always_comb begin
        n_res           = 2'd0;
        res[0]          = c;
        res[1]          = c;
        seen_cr_next    = seen_cr_reg;
        line_start_next = line_start_reg;
        seen_dot_next   = seen_dot_reg;
        if (encode_reg) begin
            if (c == CH_CR) begin
                seen_cr_next = 1'b1;
            end else if (c == CH_LF) begin
                line_start_next = 1'b1;
                if (!seen_cr_reg) begin
                    res[n_res[0]] = CH_CR;
                    n_res         = n_res + 2'd1;
                end
                seen_cr_next = 1'b0;
            end else begin
                if (dot_reg && c == CH_DOT && line_start_reg) begin
                    res[n_res[0]] = CH_DOT;
                    n_res         = n_res + 2'd1;
                end
                seen_cr_next    = 1'b0;
                line_start_next = 1'b0;
            end
            res[n_res[0]] = c;
            n_res         = n_res + 2'd1;
        end else if (c == CH_CR) begin
            seen_dot_next   = 1'b0;
            seen_cr_next    = 1'b1;
            line_start_next = 1'b0;
        end else if (seen_cr_reg && c == CH_LF) begin
            // CR LF collapses to LF; dot tracking is skipped for this byte
            seen_cr_next    = 1'b0;
            line_start_next = 1'b1;
            res[0]          = c;
            n_res           = 2'd1;
        end else begin
            if (seen_cr_reg) begin
                seen_cr_next  = 1'b0;
                res[n_res[0]] = CH_CR;
                n_res         = n_res + 2'd1;
            end
            // drop the second dot of a stuffed leading pair
            if (!(dot_reg && seen_dot_reg && c == CH_DOT)) begin
                res[n_res[0]] = c;
                n_res         = n_res + 2'd1;
            end
            if (dot_reg && c == CH_DOT) begin
                if (line_start_reg) begin
                    seen_dot_next = 1'b1;
                end else if (seen_dot_reg) begin
                    seen_dot_next = 1'b0;
                end
            end
            line_start_next = 1'b0;
        end
    end

    // Queue update: a new transfer only enters when the queue is empty after pop.
    always_comb begin
        byte_next[0] = byte_reg[0];
        byte_next[1] = byte_reg[1];
        last_next[0] = last_reg[0];
        last_next[1] = last_reg[1];
        cnt_next     = cnt_reg;
        if (s_xfer) begin
            byte_next[0] = res[0];
            byte_next[1] = res[1];
            last_next[0] = (n_res == 2'd1);
            last_next[1] = 1'b1;
            cnt_next     = n_res;
        end else if (m_xfer) begin
            byte_next[0] = byte_reg[1];
            last_next[0] = last_reg[1];
            cnt_next     = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg[0] <= byte_next[0];
        byte_reg[1] <= byte_next[1];
        last_reg[0] <= last_next[0];
        last_reg[1] <= last_next[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= 2'd0;
            encode_reg     <= 1'b1;
            dot_reg        <= 1'b0;
            seen_cr_reg    <= 1'b0;
            line_start_reg <= 1'b1;
            seen_dot_reg   <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (s_xfer) begin
                seen_cr_reg    <= seen_cr_next;
                line_start_reg <= line_start_next;
                seen_dot_reg   <= seen_dot_next;
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ENCODE_MODE: encode_reg <= cfg_wdata[0];
                    REG_DOT_MODE:    dot_reg    <= cfg_wdata[0];
                    default:         ;
                endcase
            end
        end
    end

endmodule

@@ src/crlf_chk.sv @@
// Port-level checker for the line-ending converter, bound to the top level.
// Depends on crlf_line_ending_dot_stuffing_assert.svh.
module crlf_chk (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [7:0] m_tdata,
    input logic m_tlast
);
`include "crlf_line_ending_dot_stuffing_assert.svh"

    // a stalled result holds
    `CRLF_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // input stalls only behind a waiting result
    `CRLF_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid)
    // the second byte of a pair is already queued
    `CRLF_ASSERT_NEXT(a_pair, m_tvalid && m_tready && !m_tlast, m_tvalid)
    // queue is empty right after reset
    `CRLF_ASSERT_ALWAYS(a_reset_empty, !aresetn, ##1 !m_tvalid)

endmodule

bind crlf_line_ending_dot_stuffing crlf_chk u_crlf_chk (.*);
